// ===== rtl/core/csp_pkg.sv =====
// shared constants and types for the cylinder support point pipeline
package csp_pkg;

    // fixed-point and datapath widths
    localparam int DIR_W   = 32;
    localparam int MAG_W   = 31;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam int SREM_W  = 34;
    localparam int PROD_W  = 62;
    localparam int Q_W     = 31;
    localparam int DREM_W  = 33;
    localparam int SUM_W   = 34;

    // pipeline depths of the iterative units
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;

    // configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 8'd1;

    // 1.0 in Q16.16
    localparam logic [MAG_W-1:0] FIX_ONE = 31'd65536;

    // saturation limits in the widened sum format
    localparam logic signed [SUM_W-1:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -34'sh0_8000_0000;

    // per-item flags carried alongside the datapath
    typedef struct packed {
        logic             sgn_x;
        logic             sgn_y;
        logic             sgn_z;
        logic             mnz;
        logic [MAG_W-1:0] margin;
    } pre_t;

    // dividends waiting for the lengths
    typedef struct packed {
        logic [PROD_W-1:0] rx;
        logic [PROD_W-1:0] rz;
        logic [PROD_W-1:0] mx;
        logic [PROD_W-1:0] my;
        logic [PROD_W-1:0] mz;
    } prod_t;

    // flags carried through the divider
    typedef struct packed {
        pre_t pre;
        logic lw_nz;
        logic l_nz;
    } dvs_t;

endpackage

// ===== rtl/core/csp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module csp_sqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [csp_pkg::SQ_W-1:0]      radicand,
    output logic [csp_pkg::ROOT_W-1:0]    root
);

    logic [csp_pkg::SREM_W-1:0] rem_reg  [csp_pkg::SQRT_STAGES-1];
    logic [csp_pkg::SQ_W-1:0]   op_reg   [csp_pkg::SQRT_STAGES-1];
    logic [csp_pkg::ROOT_W-1:0] root_reg [csp_pkg::SQRT_STAGES];

    for (genvar k = 0; k < csp_pkg::SQRT_STAGES; k++) begin : g_stage
        logic [csp_pkg::SREM_W-1:0] rem_in;
        logic [csp_pkg::SREM_W-1:0] rem_sh;
        logic [csp_pkg::SREM_W-1:0] trial;
        logic [csp_pkg::ROOT_W-1:0] root_in;
        logic [csp_pkg::SQ_W-1:0]   op_in;
        logic                       ge;
        logic [csp_pkg::SREM_W-1:0] rem_next;
        logic [csp_pkg::ROOT_W-1:0] root_next;

        // stage inputs
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign op_in   = radicand;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign op_in   = op_reg[k-1];
        end

        // bring in two radicand bits and try the next root bit
        assign rem_sh    = {rem_in[csp_pkg::SREM_W-3:0], op_in[csp_pkg::SQ_W-1 -: 2]};
        assign trial     = {root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[csp_pkg::ROOT_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= root_next;
            end
        end

        if (k < csp_pkg::SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    op_reg[k]  <= {op_in[csp_pkg::SQ_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[csp_pkg::SQRT_STAGES-1];

endmodule

// ===== rtl/core/csp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module csp_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [csp_pkg::PROD_W-1:0]    dividend,
    input  logic [csp_pkg::ROOT_W-1:0]    divisor,
    output logic [csp_pkg::Q_W-1:0]       quotient
);

    logic [csp_pkg::DREM_W-1:0] rem_reg [csp_pkg::DIV_STAGES-1];
    logic [csp_pkg::Q_W-1:0]    lo_reg  [csp_pkg::DIV_STAGES-1];
    logic [csp_pkg::ROOT_W-1:0] d_reg   [csp_pkg::DIV_STAGES-1];
    logic [csp_pkg::Q_W-1:0]    q_reg   [csp_pkg::DIV_STAGES];

    for (genvar k = 0; k < csp_pkg::DIV_STAGES; k++) begin : g_stage
        logic [csp_pkg::DREM_W-1:0] rem_in;
        logic [csp_pkg::Q_W-1:0]    lo_in;
        logic [csp_pkg::ROOT_W-1:0] d_in;
        logic [csp_pkg::Q_W-1:0]    q_in;
        logic [csp_pkg::DREM_W-1:0] rem_sh;
        logic                       ge;
        logic [csp_pkg::DREM_W-1:0] rem_next;

        // the high dividend bits start as the partial remainder
        if (k == 0) begin : g_first
            assign rem_in = {2'b00, dividend[csp_pkg::PROD_W-1:csp_pkg::Q_W]};
            assign lo_in  = dividend[csp_pkg::Q_W-1:0];
            assign d_in   = divisor;
            assign q_in   = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign rem_sh   = {rem_in[csp_pkg::DREM_W-2:0], lo_in[csp_pkg::Q_W-1]};
        assign ge       = (rem_sh >= {1'b0, d_in});
        assign rem_next = ge ? (rem_sh - {1'b0, d_in}) : rem_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= {q_in[csp_pkg::Q_W-2:0], ge};
            end
        end

        if (k < csp_pkg::DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    lo_reg[k]  <= {lo_in[csp_pkg::Q_W-2:0], 1'b0};
                    d_reg[k]   <= d_in;
                end
            end
        end
    end

    assign quotient = q_reg[csp_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/cylinder_support_point.sv =====
// Support point of a Y-axis cylinder with optional margin, Q16.16 in and out.
// One item enters per cycle unless the pipeline is stalled. Its stages are the
// input register, squaring and scaling multipliers, the length sums,
// a 32-stage square root (one root bit per stage), a 31-stage divider (one
// quotient bit per stage) and the output add with saturation. A stalled output
// holds the whole pipeline, so in_stall follows out_stall while a result waits.
// The user writes radius and half height via cfg port between batches; unchecked.
module cylinder_support_point (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [31:0]               dir_x,
    input  logic signed [31:0]               dir_y,
    input  logic signed [31:0]               dir_z,
    input  logic [30:0]                      margin_amount,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               sup_x,
    output logic signed [31:0]               sup_y,
    output logic signed [31:0]               sup_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);

    logic                          en;
    logic [csp_pkg::MAG_W-1:0]     radius_reg;
    logic [csp_pkg::MAG_W-1:0]     half_height_reg;

    // stage 1: magnitudes
    logic                          v1_reg;
    logic [csp_pkg::DIR_W-1:0]     ax_reg, ay_reg, az_reg;
    csp_pkg::pre_t                 pre1_reg;
    // stage 2: squares and scaled magnitudes
    logic                          v2_reg;
    logic [csp_pkg::SQ_W-1:0]      x2_reg, y2_reg, z2_reg;
    csp_pkg::prod_t                prod2_reg;
    csp_pkg::pre_t                 pre2_reg;
    logic [62:0]                   mul_rx, mul_rz, mul_mx, mul_my, mul_mz;
    // stage 3: squared lengths
    logic                          v3_reg;
    logic [csp_pkg::SQ_W-1:0]      sw_reg, sa_reg;
    csp_pkg::prod_t                prod3_reg;
    csp_pkg::pre_t                 pre3_reg;
    // alongside the square root
    logic                          vs_reg   [csp_pkg::SQRT_STAGES];
    csp_pkg::prod_t                prods_reg [csp_pkg::SQRT_STAGES];
    csp_pkg::pre_t                 pres_reg [csp_pkg::SQRT_STAGES];
    logic [csp_pkg::ROOT_W-1:0]    lw, l;
    // alongside the divider
    logic                          vd_reg   [csp_pkg::DIV_STAGES];
    csp_pkg::dvs_t                 dvs_reg  [csp_pkg::DIV_STAGES];
    logic [csp_pkg::Q_W-1:0]       q_rx, q_rz, q_mx, q_my, q_mz;
    // output stage
    logic                          out_valid_reg;
    logic signed [31:0]            sup_x_reg, sup_y_reg, sup_z_reg;
    logic signed [csp_pkg::SUM_W-1:0] sum_x, sum_y, sum_z;
    csp_pkg::dvs_t                 fin;

    // whole pipeline moves unless a finished item is held
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= csp_pkg::FIX_ONE;
            half_height_reg <= csp_pkg::FIX_ONE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                csp_pkg::CFG_RADIUS:      radius_reg      <= cfg_data[30:0];
                csp_pkg::CFG_HALF_HEIGHT: half_height_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < csp_pkg::SQRT_STAGES; i++) vs_reg[i] <= 1'b0;
            for (int i = 0; i < csp_pkg::DIV_STAGES; i++)  vd_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vs_reg[0] <= v3_reg;
            for (int i = 1; i < csp_pkg::SQRT_STAGES; i++) vs_reg[i] <= vs_reg[i-1];
            vd_reg[0] <= vs_reg[csp_pkg::SQRT_STAGES-1];
            for (int i = 1; i < csp_pkg::DIV_STAGES; i++)  vd_reg[i] <= vd_reg[i-1];
            out_valid_reg <= vd_reg[csp_pkg::DIV_STAGES-1];
        end
    end

    // stage 1: magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg          <= dir_x[31] ? 32'(-dir_x) : 32'(dir_x);
            ay_reg          <= dir_y[31] ? 32'(-dir_y) : 32'(dir_y);
            az_reg          <= dir_z[31] ? 32'(-dir_z) : 32'(dir_z);
            pre1_reg.sgn_x  <= dir_x[31];
            pre1_reg.sgn_y  <= dir_y[31];
            pre1_reg.sgn_z  <= dir_z[31];
            pre1_reg.mnz    <= (margin_amount != '0);
            pre1_reg.margin <= margin_amount;
        end
    end

    // stage 2: squares and scale products
    assign mul_rx = radius_reg * ax_reg;
    assign mul_rz = radius_reg * az_reg;
    assign mul_mx = pre1_reg.margin * ax_reg;
    assign mul_my = pre1_reg.margin * ay_reg;
    assign mul_mz = pre1_reg.margin * az_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg       <= ax_reg * ax_reg;
            y2_reg       <= ay_reg * ay_reg;
            z2_reg       <= az_reg * az_reg;
            prod2_reg.rx <= mul_rx[csp_pkg::PROD_W-1:0];
            prod2_reg.rz <= mul_rz[csp_pkg::PROD_W-1:0];
            prod2_reg.mx <= mul_mx[csp_pkg::PROD_W-1:0];
            prod2_reg.my <= mul_my[csp_pkg::PROD_W-1:0];
            prod2_reg.mz <= mul_mz[csp_pkg::PROD_W-1:0];
            pre2_reg     <= pre1_reg;
        end
    end

    // stage 3: squared lengths of the XZ part and the whole vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sw_reg    <= x2_reg + z2_reg;
            sa_reg    <= x2_reg + y2_reg + z2_reg;
            prod3_reg <= prod2_reg;
            pre3_reg  <= pre2_reg;
        end
    end

    // lengths
    csp_sqrt u_sqrt_xz (.clk(clk), .en(en), .radicand(sw_reg), .root(lw));
    csp_sqrt u_sqrt_all (.clk(clk), .en(en), .radicand(sa_reg), .root(l));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prods_reg[0] <= prod3_reg;
            pres_reg[0]  <= pre3_reg;
            for (int i = 1; i < csp_pkg::SQRT_STAGES; i++)
            begin
                prods_reg[i] <= prods_reg[i-1];
                pres_reg[i]  <= pres_reg[i-1];
            end
        end
    end

    // scaled components
    csp_div u_div_rx (.clk(clk), .en(en),
        .dividend(prods_reg[csp_pkg::SQRT_STAGES-1].rx), .divisor(lw), .quotient(q_rx));
    csp_div u_div_rz (.clk(clk), .en(en),
        .dividend(prods_reg[csp_pkg::SQRT_STAGES-1].rz), .divisor(lw), .quotient(q_rz));
    csp_div u_div_mx (.clk(clk), .en(en),
        .dividend(prods_reg[csp_pkg::SQRT_STAGES-1].mx), .divisor(l), .quotient(q_mx));
    csp_div u_div_my (.clk(clk), .en(en),
        .dividend(prods_reg[csp_pkg::SQRT_STAGES-1].my), .divisor(l), .quotient(q_my));
    csp_div u_div_mz (.clk(clk), .en(en),
        .dividend(prods_reg[csp_pkg::SQRT_STAGES-1].mz), .divisor(l), .quotient(q_mz));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg[0].pre   <= pres_reg[csp_pkg::SQRT_STAGES-1];
            dvs_reg[0].lw_nz <= (lw != '0);
            dvs_reg[0].l_nz  <= (l != '0);
            for (int i = 1; i < csp_pkg::DIV_STAGES; i++) dvs_reg[i] <= dvs_reg[i-1];
        end
    end

    // rim point plus margin push
    assign fin = dvs_reg[csp_pkg::DIV_STAGES-1];

    always_comb
    begin
        sum_x = '0;
        sum_z = '0;
        sum_y = fin.pre.sgn_y ? -$signed({3'b000, half_height_reg})
                              :  $signed({3'b000, half_height_reg});
        if (fin.lw_nz)
        begin
            sum_x = fin.pre.sgn_x ? -$signed({3'b000, q_rx}) : $signed({3'b000, q_rx});
            sum_z = fin.pre.sgn_z ? -$signed({3'b000, q_rz}) : $signed({3'b000, q_rz});
        end
        if (fin.pre.mnz)
        begin
            if (fin.l_nz)
            begin
                sum_x = sum_x + (fin.pre.sgn_x ? -$signed({3'b000, q_mx})
                                               :  $signed({3'b000, q_mx}));
                sum_y = sum_y + (fin.pre.sgn_y ? -$signed({3'b000, q_my})
                                               :  $signed({3'b000, q_my}));
                sum_z = sum_z + (fin.pre.sgn_z ? -$signed({3'b000, q_mz})
                                               :  $signed({3'b000, q_mz}));
            end
            else
            begin
                sum_y = sum_y + $signed({3'b000, fin.pre.margin});
            end
        end
    end

    // output register with saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sup_x_reg <= (sum_x > csp_pkg::SAT_MAX) ? 32'sh7FFF_FFFF :
                         (sum_x < csp_pkg::SAT_MIN) ? -32'sh8000_0000 : 32'(sum_x);
            sup_y_reg <= (sum_y > csp_pkg::SAT_MAX) ? 32'sh7FFF_FFFF :
                         (sum_y < csp_pkg::SAT_MIN) ? -32'sh8000_0000 : 32'(sum_y);
            sup_z_reg <= (sum_z > csp_pkg::SAT_MAX) ? 32'sh7FFF_FFFF :
                         (sum_z < csp_pkg::SAT_MIN) ? -32'sh8000_0000 : 32'(sum_z);
        end
    end

    assign out_valid = out_valid_reg;
    assign sup_x     = sup_x_reg;
    assign sup_y     = sup_y_reg;
    assign sup_z     = sup_z_reg;

`ifndef ASSERT_OFF
    // an accepted item enters the first stage
    ast_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted item did not enter the pipeline");

    // a held result is not dropped
    ast_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("held result was lost");

    // rim quotient never exceeds the radius
    ast_rim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vd_reg[csp_pkg::DIV_STAGES-1] && fin.lw_nz) |-> (q_rx <= radius_reg))
        else $error("rim quotient above radius");
`endif

endmodule
